// ===== rtl/mexp_pkg.sv =====
`default_nettype none
package mexp_pkg;

	localparam int EXP_BITS_DEF = 32;
	localparam int MOD_W        = 31;
	localparam int DATA_W       = 32;
	localparam int MUL_STEPS    = DATA_W;
	localparam int CNT_W        = $clog2(MUL_STEPS);

	localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

	typedef struct packed {
		logic load;
		logic start_mul;
		logic start_sqr;
		logic step;
		logic wr_acc;
		logic wr_sq;
		logic shift_e;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic e_bit;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/mexp_ctrl.sv =====
`default_nettype none
module mexp_ctrl #(
	parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  mexp_pkg::sts_t     sts,
	output mexp_pkg::cmd_t     cmd
);

	localparam int BIT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RED  = 7'b0000010,
		S_BIT  = 7'b0000100,
		S_MUL  = 7'b0001000,
		S_SQS  = 7'b0010000,
		S_SQR  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t                      state_q, state_d;
	logic [mexp_pkg::CNT_W-1:0]  cnt_q;
	logic [BIT_W-1:0]            bit_q;
	logic                        cnt_last;
	logic                        bit_last;

	assign cnt_last = (cnt_q == mexp_pkg::CNT_W'(mexp_pkg::MUL_STEPS - 1));
	assign bit_last = (bit_q == BIT_W'(EXP_BITS - 1));

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RED;
				end
			end
			S_RED: begin
				cmd.step = 1'b1;
				if (cnt_last) begin
					cmd.wr_sq = 1'b1;
					state_d   = S_BIT;
				end
			end
			S_BIT: begin
				if (sts.e_bit) begin
					cmd.start_mul = 1'b1;
					state_d       = S_MUL;
				end else begin
					cmd.start_sqr = 1'b1;
					state_d       = S_SQR;
				end
			end
			S_MUL: begin
				cmd.step = 1'b1;
				if (cnt_last) begin
					cmd.wr_acc = 1'b1;
					state_d    = S_SQS;
				end
			end
			S_SQS: begin
				cmd.start_sqr = 1'b1;
				state_d       = S_SQR;
			end
			S_SQR: begin
				cmd.step = 1'b1;
				if (cnt_last) begin
					cmd.wr_sq   = 1'b1;
					cmd.shift_e = 1'b1;
					state_d     = bit_last ? S_OUT : S_BIT;
				end
			end
			S_OUT: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.load) begin
				bit_q <= '0;
			end else if (cmd.shift_e) begin
				bit_q <= bit_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mexp_dp.sv =====
`default_nettype none
module mexp_dp #(
	parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	input  wire logic [mexp_pkg::MOD_W-1:0]    cfg_data,
	input  wire logic                          op,
	input  wire logic [mexp_pkg::DATA_W-1:0]   base,
	input  wire logic [mexp_pkg::DATA_W-1:0]   exponent,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [mexp_pkg::MOD_W-1:0]         power_result,
	input  mexp_pkg::cmd_t                     cmd,
	output mexp_pkg::sts_t                     sts
);

	localparam int MW = mexp_pkg::MOD_W;
	localparam int DW = mexp_pkg::DATA_W;

	logic [MW-1:0]       m_q;
	logic [MW-1:0]       acc_q;
	logic [MW-1:0]       sq_q;
	logic [MW-1:0]       r_q;
	logic [MW-1:0]       y_q;
	logic [DW-1:0]       x_q;
	logic [EXP_BITS-1:0] e_q;
	logic [MW-1:0]       res_q;
	logic                out_valid_q;

	logic [MW:0]         r2;
	logic [MW-1:0]       r2r;
	logic [MW-1:0]       addend;
	logic [MW:0]         r3;
	logic [MW-1:0]       r_next;
	logic [MW-1:0]       m_minus2;
	logic [63:0]         e_wide;

	assign r2     = {r_q, 1'b0};
	assign r2r    = (r2 >= {1'b0, m_q}) ? MW'(r2 - {1'b0, m_q}) : r2[MW-1:0];
	assign addend = x_q[DW-1] ? y_q : '0;
	assign r3     = {1'b0, r2r} + {1'b0, addend};
	assign r_next = (r3 >= {1'b0, m_q}) ? MW'(r3 - {1'b0, m_q}) : r3[MW-1:0];

	assign m_minus2 = (m_q >= MW'(2)) ? MW'(m_q - MW'(2)) : '0;
	assign e_wide   = op ? {{(64-MW){1'b0}}, m_minus2} : {{(64-DW){1'b0}}, exponent};

	assign sts.e_bit    = e_q[0];
	assign sts.out_busy = out_valid_q && !out_ready;

	assign out_valid    = out_valid_q;
	assign power_result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q         <= mexp_pkg::MOD_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				m_q <= cfg_data;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q   <= base;
			y_q   <= MW'(1);
			r_q   <= '0;
			e_q   <= e_wide[EXP_BITS-1:0];
			acc_q <= (m_q == MW'(1)) ? '0 : MW'(1);
		end else if (cmd.start_mul) begin
			x_q <= {{(DW-MW){1'b0}}, acc_q};
			y_q <= sq_q;
			r_q <= '0;
		end else if (cmd.start_sqr) begin
			x_q <= {{(DW-MW){1'b0}}, sq_q};
			y_q <= sq_q;
			r_q <= '0;
		end else if (cmd.step) begin
			x_q <= {x_q[DW-2:0], 1'b0};
			r_q <= r_next;
		end
		if (cmd.wr_acc) begin
			acc_q <= r_next;
		end
		if (cmd.wr_sq) begin
			sq_q <= r_next;
		end
		if (cmd.shift_e) begin
			e_q <= e_q >> 1;
		end
		if (cmd.finish) begin
			res_q <= (m_q == '0) ? '0 : acc_q;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/modular_exponentiation_top.sv =====
// Computes base to the power exponent modulo the configured modulus (reset value 1000000007),
// or, with op set, base to the power modulus minus two, which is the inverse for a prime
// modulus; only the low EXP_BITS bits of the exponent are scanned. One request is worked at
// a time on one shared bit-serial modular multiplier, which forms one product to reduce the
// base, one square per exponent bit and one multiply per set bit. A finished result waits
// in an output register while the next request is taken. The user must write the modulus
// through the configuration channel only while the block is idle; the block itself does
// not enforce it. A modulus of zero gives zero.
`default_nettype none
module modular_exponentiation_top #(
	parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [mexp_pkg::MOD_W-1:0]    cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          op,
	input  wire logic [mexp_pkg::DATA_W-1:0]   base,
	input  wire logic [mexp_pkg::DATA_W-1:0]   exponent,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [mexp_pkg::MOD_W-1:0]         power_result
);

	mexp_pkg::cmd_t cmd;
	mexp_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	mexp_ctrl #(
		.EXP_BITS(EXP_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mexp_dp #(
		.EXP_BITS(EXP_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.op           (op),
		.base         (base),
		.exponent     (exponent),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.power_result (power_result),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule
`default_nettype wire

// ===== test/modular_exponentiation_checker.sv =====
module modular_exponentiation_checker #(
	parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [mexp_pkg::MOD_W-1:0]    cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          op,
	input  logic [mexp_pkg::DATA_W-1:0]   base,
	input  logic [mexp_pkg::DATA_W-1:0]   exponent,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [mexp_pkg::MOD_W-1:0]    power_result,
	output int                            failures,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [mexp_pkg::MOD_W-1:0] modulus;
	logic [mexp_pkg::MOD_W-1:0] expected_powers[$];
	logic [mexp_pkg::MOD_W-1:0] oldest_power;

	// Right-to-left square and multiply; an inverse request uses modulus minus two.
	function automatic logic [mexp_pkg::MOD_W-1:0] mod_power(
		input logic                        invert,
		input logic [mexp_pkg::DATA_W-1:0] b,
		input logic [mexp_pkg::DATA_W-1:0] e,
		input logic [mexp_pkg::MOD_W-1:0]  m
	);
		longint unsigned acc;
		longint unsigned sq;
		longint unsigned mm;
		logic [63:0] scan;
		if (m == '0) begin
			return '0;
		end
		mm = m;
		scan = invert ? ((m >= 2) ? 64'(m - 2) : 64'd0) : 64'(e);
		acc = 64'd1 % mm;
		sq = 64'(b) % mm;
		for (int i = 0; i < EXP_BITS; i++) begin
			if (scan[0]) begin
				acc = (acc * sq) % mm;
			end
			sq = (sq * sq) % mm;
			scan = scan >> 1;
		end
		return acc[mexp_pkg::MOD_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus <= mexp_pkg::MOD_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				modulus <= cfg_data;
			end
			if (in_valid && in_ready) begin
				expected_powers.push_back(mod_power(op, base, exponent, modulus));
			end
			if (out_valid && out_ready) begin
				if (expected_powers.size() == 0) begin
					$error("power_result: expected none, actual %0d", power_result);
					failures <= failures + 1;
				end else begin
					oldest_power = expected_powers.pop_front();
					if (power_result !== oldest_power) begin
						$error("power_result: expected %0d, actual %0d",
							oldest_power, power_result);
						failures <= failures + 1;
					end
				end
			end
			outstanding <= expected_powers.size();
		end
	end

endmodule

// ===== test/modular_exponentiation_top_test.sv =====
module modular_exponentiation_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_POWER   = 1'b0;
	localparam logic OP_INVERSE = 1'b1;
	localparam int   PHASES     = 8;
	localparam int   PHASE_ITEMS = 33;
	localparam int   HOLD_CYCLES = 6000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [mexp_pkg::MOD_W-1:0]    cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          op = OP_POWER;
	logic [mexp_pkg::DATA_W-1:0]   base = '0;
	logic [mexp_pkg::DATA_W-1:0]   exponent = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [mexp_pkg::MOD_W-1:0]    power_result;

	int   failures;
	int   outstanding;
	int   tx_idle_pct = 7;
	int   rx_idle_pct = 63;
	logic rx_hold = 1'b0;
	logic start_hold = 1'b0;
	logic [mexp_pkg::MOD_W-1:0] cur_modulus = mexp_pkg::MOD_RESET;

	modular_exponentiation_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.base         (base),
		.exponent     (exponent),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.power_result (power_result)
	);

	modular_exponentiation_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.base         (base),
		.exponent     (exponent),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.power_result (power_result),
		.failures     (failures),
		.outstanding  (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// The receiver holds off for a long stretch so that the block fills and stalls its input.
	initial begin
		wait (start_hold);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#30_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic offer(input logic o, input logic [31:0] b, input logic [31:0] e);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		base <= b;
		exponent <= e;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_modulus(input logic [mexp_pkg::MOD_W-1:0] m);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_modulus = m;
	endtask

	initial begin
		logic [31:0] b;
		logic [31:0] e;
		logic        o;
		logic [mexp_pkg::MOD_W-1:0] m;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(OP_POWER, 32'd0, 32'd0);
		offer(OP_POWER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer(OP_POWER, 32'd1000000007, 32'd5);
		offer(OP_POWER, 32'd3, 32'h8000_0000);
		offer(OP_POWER, 32'd2, 32'd31);
		offer(OP_INVERSE, 32'd12345, 32'd0);
		offer(OP_INVERSE, 32'd2000000014, 32'hFFFF_FFFF);
		offer(OP_INVERSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		write_modulus(31'h7FFF_FFFF);
		offer(OP_POWER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer(OP_INVERSE, 32'd2147483646, 32'd0);
		offer(OP_POWER, 32'd2147483647, 32'd0);

		write_modulus(31'd1);
		offer(OP_POWER, 32'd5, 32'd0);
		offer(OP_INVERSE, 32'd5, 32'd0);

		write_modulus(31'd0);
		offer(OP_POWER, 32'd5, 32'd3);
		offer(OP_INVERSE, 32'hFFFF_FFFF, 32'd0);

		write_modulus(31'd2);
		offer(OP_INVERSE, 32'd4, 32'd0);
		offer(OP_POWER, 32'd3, 32'd7);

		write_modulus(31'd15);
		offer(OP_INVERSE, 32'd7, 32'd9);
		offer(OP_POWER, 32'd7, 32'hFFFF_FFFF);

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: m = 31'd998244353;
				1: m = 31'h7FFF_FFFF;
				2: m = 31'($urandom_range(1, 32'h7FFF_FFFF));
				3: m = 31'd65537;
				4: m = 31'($urandom_range(1, 64));
				5: m = 31'd97;
				6: m = 31'($urandom_range(1, 32'h7FFF_FFFF));
				default: m = mexp_pkg::MOD_RESET;
			endcase
			write_modulus(m);
			if (phase == 3) begin
				tx_idle_pct = 63;
				rx_idle_pct <= 7;
			end else if (phase == 6) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
				start_hold = 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				o = ($urandom_range(0, 3) == 0) ? OP_INVERSE : OP_POWER;
				case ($urandom_range(0, 9))
					0: b = 32'd0;
					1: b = 32'(cur_modulus) * $urandom_range(1, 3);
					2: b = 32'(cur_modulus) - 32'd1;
					3: b = $urandom_range(0, 15);
					default: b = $urandom;
				endcase
				case ($urandom_range(0, 7))
					0: e = 32'd0;
					1: e = 32'hFFFF_FFFF;
					2: e = $urandom_range(0, 40);
					default: e = $urandom;
				endcase
				offer(o, b, e);
			end
		end

		drain();
		repeat (200) @(posedge clk);
		if (failures == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
